[rtl/alt_pkg.sv]
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants for the assembly line tokenizer
// Result record layout, result kinds and the character codes the scanner
// reacts to.
// ----------------------------------------------------------------------------
package alt_pkg;

    localparam logic [1:0] KIND_TOKEN    = 2'd0;
    localparam logic [1:0] KIND_LINE_END = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  first;
        logic [7:0]  last;
        logic [15:0] line;
        logic        had_tokens;
        logic        clipped;
        logic        last_of_run;
    } t_result;

    // Everything the scanner hands to the result queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        logic       halted;
    } t_scan_out;

endpackage

[rtl/alt_scan.sv]
// ----------------------------------------------------------------------------
// alt_scan: per-character scanner
// Holds the scan mode and line state and forms up to two results for the
// character on i_char while i_go is high.
// ----------------------------------------------------------------------------
module alt_scan #(
    parameter int MAX_LINE_LEN = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [7:0]          i_char,
    output alt_pkg::t_scan_out  o_scan
);
    import alt_pkg::*;

    localparam int POS_LIMIT = (MAX_LINE_LEN - 1 < 255) ? MAX_LINE_LEN - 1 : 255;
    localparam logic [7:0] POS_LIM = 8'(POS_LIMIT);

    localparam logic [1:0] OVF_NONE = 2'd0;
    localparam logic [1:0] OVF_NEAR = 2'd1;
    localparam logic [1:0] OVF_FAR  = 2'd2;

    typedef enum logic [1:0] {M_SEARCH, M_GRAB, M_QUOTE, M_IGNORE} t_mode;

    t_mode       r_mode,  n_mode;
    logic        r_halted, n_halted;
    logic [7:0]  r_pos,   n_pos;
    logic [7:0]  r_begin, n_begin;
    logic        r_bclip, n_bclip;
    logic [1:0]  r_ovf,   n_ovf;
    logic        r_bs,    n_bs;
    logic        r_tok,   n_tok;
    logic [15:0] r_line,  n_line;

    logic [7:0] prev_pos;
    logic       cur_clip, prev_clip, blank, line_end, err;
    logic [1:0] k;
    t_result    res0, res1;

    function automatic t_result mk(input logic [1:0] kind, input logic [7:0] first,
                                   input logic [7:0] last, input logic [15:0] line,
                                   input logic tok, input logic clip);
        t_result r;
        r.kind        = kind;
        r.first       = first;
        r.last        = last;
        r.line        = line;
        r.had_tokens  = tok;
        r.clipped     = clip;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    assign cur_clip  = (r_ovf != OVF_NONE);
    assign prev_clip = (r_ovf == OVF_FAR);
    assign prev_pos  = cur_clip ? POS_LIM : ((r_pos != 8'd0) ? r_pos - 8'd1 : 8'd0);
    assign blank     = (i_char == CH_SPACE) || (i_char == CH_TAB);

    always_comb begin
        n_mode   = r_mode;
        n_halted = r_halted;
        n_pos    = r_pos;
        n_begin  = r_begin;
        n_bclip  = r_bclip;
        n_ovf    = r_ovf;
        n_bs     = r_bs;
        n_tok    = r_tok;
        n_line   = r_line;
        res0     = '0;
        res1     = '0;
        k        = 2'd0;
        line_end = 1'b0;
        err      = 1'b0;
        if (i_go && !r_halted) begin
            unique case (r_mode)
                M_SEARCH: begin
                    if (i_char == CH_END) begin
                        line_end = 1'b1;
                    end else if (blank) begin
                        n_mode = M_SEARCH;
                    end else if (i_char == CH_SEMI) begin
                        n_mode = M_IGNORE;
                    end else begin
                        n_begin = r_pos;
                        n_bclip = cur_clip;
                        n_mode  = (i_char == CH_QUOTE) ? M_QUOTE : M_GRAB;
                    end
                end
                M_GRAB: begin
                    if (i_char == CH_END || blank) begin
                        n_tok    = 1'b1;
                        res0     = mk(KIND_TOKEN, r_begin, prev_pos, r_line, 1'b1,
                                      r_bclip | prev_clip);
                        k        = 2'd1;
                        n_mode   = M_SEARCH;
                        line_end = (i_char == CH_END);
                    end else if (i_char == CH_COMMA) begin
                        // close the word, then the comma is a token of its own
                        n_tok   = 1'b1;
                        res0    = mk(KIND_TOKEN, r_begin, prev_pos, r_line, 1'b1,
                                     r_bclip | prev_clip);
                        res1    = mk(KIND_TOKEN, r_pos, r_pos, r_line, 1'b1, cur_clip);
                        n_begin = r_pos;
                        n_bclip = cur_clip;
                        k       = 2'd2;
                        n_mode  = M_SEARCH;
                    end else if (i_char == CH_SEMI) begin
                        n_tok  = 1'b1;
                        res0   = mk(KIND_TOKEN, r_begin, prev_pos, r_line, 1'b1,
                                    r_bclip | prev_clip);
                        k      = 2'd1;
                        n_mode = M_IGNORE;
                    end
                end
                M_QUOTE: begin
                    if (i_char == CH_END) begin
                        res0     = mk(KIND_ERROR, r_begin, r_pos, r_line, r_tok,
                                      r_bclip | cur_clip);
                        k        = 2'd1;
                        n_halted = 1'b1;
                        err      = 1'b1;
                    end else if (blank) begin
                        n_tok  = 1'b1;
                        res0   = mk(KIND_TOKEN, r_begin, prev_pos, r_line, 1'b1,
                                    r_bclip | prev_clip);
                        k      = 2'd1;
                        n_mode = M_SEARCH;
                    end else if (i_char == CH_QUOTE && !r_bs) begin
                        n_tok  = 1'b1;
                        res0   = mk(KIND_TOKEN, r_begin, r_pos, r_line, 1'b1,
                                    r_bclip | cur_clip);
                        k      = 2'd1;
                        n_mode = M_SEARCH;
                    end
                end
                M_IGNORE: begin
                    if (i_char == CH_END) begin
                        line_end = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_SEARCH;
                end
            endcase

            if (!err) begin
                if (line_end) begin
                    if (k == 2'd0) begin
                        res0 = mk(KIND_LINE_END, 8'd0, 8'd0, r_line, n_tok, cur_clip);
                    end else begin
                        res1 = mk(KIND_LINE_END, 8'd0, 8'd0, r_line, n_tok, cur_clip);
                    end
                    k       = k + 2'd1;
                    n_mode  = M_SEARCH;
                    n_pos   = 8'd0;
                    n_begin = 8'd0;
                    n_bclip = 1'b0;
                    n_ovf   = OVF_NONE;
                    n_bs    = 1'b0;
                    n_tok   = 1'b0;
                    n_line  = r_line + 16'd1;
                end else begin
                    n_bs = (i_char == CH_BSLASH);
                    if (r_ovf != OVF_NONE) begin
                        n_ovf = OVF_FAR;
                    end else if (r_pos < POS_LIM) begin
                        n_pos = r_pos + 8'd1;
                    end else begin
                        n_ovf = OVF_NEAR;
                    end
                end
            end

            if (k == 2'd2) begin
                res1.last_of_run = 1'b1;
            end else if (k == 2'd1) begin
                res0.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_SEARCH;
            r_halted <= 1'b0;
            r_pos    <= 8'd0;
            r_begin  <= 8'd0;
            r_bclip  <= 1'b0;
            r_ovf    <= OVF_NONE;
            r_bs     <= 1'b0;
            r_tok    <= 1'b0;
            r_line   <= 16'd1;
        end else begin
            r_mode   <= n_mode;
            r_halted <= n_halted;
            r_pos    <= n_pos;
            r_begin  <= n_begin;
            r_bclip  <= n_bclip;
            r_ovf    <= n_ovf;
            r_bs     <= n_bs;
            r_tok    <= n_tok;
            r_line   <= n_line;
        end
    end

    assign o_scan.count  = k;
    assign o_scan.res0   = res0;
    assign o_scan.res1   = res1;
    assign o_scan.halted = r_halted;

endmodule

[rtl/alt_outq.sv]
// ----------------------------------------------------------------------------
// alt_outq: result queue
// Four-entry queue that takes up to two results per cycle and gives one while i_stall is low.
// ----------------------------------------------------------------------------
module alt_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_count,
    input  alt_pkg::t_result  i_res0,
    input  alt_pkg::t_result  i_res1,
    input  logic              i_stall,
    output logic              o_valid,
    output alt_pkg::t_result  o_data,
    output logic              o_room_two
);
    import alt_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wptr, r_rptr;
    logic [2:0] r_count;
    logic       pop;

    assign o_valid    = (r_count != 3'd0);
    assign o_data     = r_mem[r_rptr];
    assign o_room_two = (r_count <= 3'd2);
    assign pop        = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wptr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wptr + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 2'd0;
            r_rptr  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wptr  <= r_wptr + i_push_count;
            r_rptr  <= r_rptr + {1'b0, pop};
            r_count <= r_count + {1'b0, i_push_count} - {2'b00, pop};
        end
    end

endmodule

[rtl/assembly_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// assembly_line_tokenizer: character-stream tokenizer for assembly source
// Splits lines into tokens and reports token positions, line ends and
// unterminated-string errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one source byte per request on i_char_code, i_in_valid
//   with o_in_stall. Code 0 ends the line.
//   Output channel: one result per request, o_out_valid with i_out_stall.
//   A character gives zero, one or two results; last_of_run marks the final
//   one of each character.
//   Path: a taken character waits in the input register while the scanner
//   forms its results, which are written into the result queue, whose head
//   drives the output.
//   Throughput: one character per cycle while the four-entry result queue
//   has room for two, as the scanner runs only then; a comma that closes a
//   word gives two results to the output, and a stalled receiver backs up into
//   o_in_stall once the queue holds three results and a character waits in
//   the input register.
//   Reset (synchronous, active low) empties the queue, returns to search
//   mode at line 1 and clears the halt that an open quote at line end sets.
//   While halted, characters are taken and dropped.
// ----------------------------------------------------------------------------
module assembly_line_tokenizer #(
    parameter int MAX_LINE_LEN = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_token_first,
    output logic [7:0]  o_token_last,
    output logic [15:0] o_line_count,
    output logic        o_line_had_tokens,
    output logic        o_position_clipped,
    output logic        o_last_of_run
);
    import alt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       room_two, process, load;
    t_scan_out  scan;
    t_result    head;

    // Advance the input register whenever the scanner consumes it.
    assign process    = r_in_valid && room_two;
    assign o_in_stall = r_in_valid && !room_two;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the character while the queue lacks room for two results.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_char <= i_char_code;
        end
    end

    alt_scan #(
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (process),
        .i_char  (r_in_char),
        .o_scan  (scan)
    );

    alt_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (scan.count),
        .i_res0       (scan.res0),
        .i_res1       (scan.res1),
        .i_stall      (i_out_stall),
        .o_valid      (o_out_valid),
        .o_data       (head),
        .o_room_two   (room_two)
    );

    assign o_result_kind      = head.kind;
    assign o_token_first      = head.first;
    assign o_token_last       = head.last;
    assign o_line_count       = head.line;
    assign o_line_had_tokens  = head.had_tokens;
    assign o_position_clipped = head.clipped;
    assign o_last_of_run      = head.last_of_run;

`ifndef ASSERT_OFF
    // A held character must not change while the scanner waits on the queue.
    a_hold_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && (r_in_char == $past(r_in_char)))
        else $error("input register lost a stalled character");

    // Drop everything once halted.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan.halted |-> (scan.count == 2'd0))
        else $error("halted scanner produced a result");

    // With two results, only the second closes the run.
    a_run_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan.count == 2'd2) |-> (scan.res1.last_of_run && !scan.res0.last_of_run))
        else $error("last_of_run misplaced on a result pair");
`endif

endmodule
